// ===== design/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants for the per-lane credit flow control block.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int CNT_W   = 24;
  localparam int BYTES_W = 16;
  localparam int QUOT_W  = 17;
  localparam int DEN_W   = 32;
  localparam int STEP_W  = 5;

  localparam logic [CNT_W-1:0]  CNT_MAX     = 24'hFFFFFF;
  localparam logic [STEP_W-1:0] CELL_STEPS  = 5'd17;
  localparam logic [STEP_W-1:0] GRAIN_STEPS = 5'd8;
  localparam logic [7:0]        GRAIN_SAT   = 8'd255;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_FLIT_BYTES  = 2'd0;
  localparam logic [1:0] REG_FLITS_CELL  = 2'd1;
  localparam logic [1:0] REG_RET_GRAIN   = 2'd2;
  localparam logic [1:0] REG_INIT_CREDIT = 2'd3;

  localparam logic [7:0]       RST_FLIT_BYTES  = 8'd16;
  localparam logic [7:0]       RST_FLITS_CELL  = 8'd4;
  localparam logic [7:0]       RST_RET_GRAIN   = 8'd1;
  localparam logic [CNT_W-1:0] RST_INIT_CREDIT = 24'd256;

  typedef enum logic [1:0] {
    CMD_TX      = 2'd0,
    CMD_CREDIT  = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [7:0]       grain;       // return grain, zero taken as one
    logic [15:0]      cell_bytes;  // bytes per credit cell
    logic [15:0]      grain_max;   // 255 grains in cells
    logic [CNT_W-1:0] init_credit;
    logic             credit_load; // initial credit written
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  num;
    logic [DEN_W-1:0]  den;   // divisor, pre-shifted to the top quotient bit
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [CNT_W-1:0]  rem;
  } div_rsp_t;

endpackage

// ===== design/cfc_if.sv =====
// ----------------------------------------------------------------------------
// cfc_if
// Request and response channels of the credit flow control block.
// ----------------------------------------------------------------------------
interface cfc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  lane;
  logic [15:0] pkt_bytes;
  logic        is_control;
  logic [7:0]  grains_in;

  modport source (output valid, cmd, lane, pkt_bytes, is_control, grains_in, input ready);
  modport sink   (input valid, cmd, lane, pkt_bytes, is_control, grains_in, output ready);
endinterface

interface cfc_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_granted;
  logic       credit_valid;
  logic [3:0] credit_lane;
  logic [7:0] credit_grains;

  modport source (output valid, tx_granted, credit_valid, credit_lane, credit_grains,
                  input ready);
  modport sink   (input valid, tx_granted, credit_valid, credit_lane, credit_grains,
                  output ready);
endinterface

// ===== design/credit_flow_control_per_lane.sv =====
// Sequence: a credit return or control packet goes from S_READ to S_DONE; a transmit
//   request adds S_CELLS; a receive buffer release adds S_CELLS and S_PCHK, plus S_GRAIN
//   when the grains split. One request at a time, taken the cycle after its
//   predecessor's response is registered; the 17-step shared divider turns bytes
//   into cells, and 8 more steps split the grains.
// Reset: counters read as their initial values through per-lane valid bits.
// ----------------------------------------------------------------------------
// credit_flow_control_per_lane
// Per virtual lane credit flow control: transmit credit check, partner
// credit return and grain-based credit return towards the partner.
// ----------------------------------------------------------------------------
module credit_flow_control_per_lane #(
  parameter int NUM_LANES = 16
) (
  input  logic        clk,
  input  logic        rst,
  cfc_req_if.sink     req,
  cfc_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfc_pkg::*;

  localparam int AW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CELLS,
    S_PCHK,
    S_GRAIN,
    S_DONE
  } state_t;

  state_t           state;
  cfg_t             cfg;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Latched request
  logic [1:0]       cmd;
  logic [3:0]       lane;
  logic [15:0]      pkt_bytes;
  logic             is_control;
  logic [7:0]       grains_in;

  // Result under construction
  logic             res_granted;
  logic             res_cvalid;
  logic [3:0]       res_lane;
  logic [7:0]       res_grains;

  logic [CNT_W-1:0] pend;     // pending return after adding the released cells
  logic             acc;
  logic             lane_ok;

  logic [CNT_W-1:0] tx_rd;
  logic [CNT_W-1:0] pd_rd;
  logic             tx_we;
  logic [CNT_W-1:0] tx_wd;
  logic             pd_we;
  logic [CNT_W-1:0] pd_wd;

  logic [QUOT_W-1:0] cells;
  logic [15:0]       credit_prod;
  logic [CNT_W:0]    credit_sum;
  logic [CNT_W:0]    pend_sum;
  logic              pend_ge_grain;
  logic              pend_ge_max;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign lane_ok   = {1'b0, req.lane} < 5'(NUM_LANES);

  cfc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Transmit credit: writing initial credit reloads every lane
  cfc_lane_mem #(.NUM_LANES(NUM_LANES), .AW(AW)) u_tx_mem (
    .clk      (clk),
    .rst      (rst),
    .clr      (cfg.credit_load),
    .rd_en    (acc),
    .rd_addr  (req.lane[AW-1:0]),
    .wr_en    (tx_we),
    .wr_addr  (lane[AW-1:0]),
    .wr_data  (tx_wd),
    .init_val (cfg.init_credit),
    .rd_data  (tx_rd)
  );

  cfc_lane_mem #(.NUM_LANES(NUM_LANES), .AW(AW)) u_pend_mem (
    .clk      (clk),
    .rst      (rst),
    .clr      (1'b0),
    .rd_en    (acc),
    .rd_addr  (req.lane[AW-1:0]),
    .wr_en    (pd_we),
    .wr_addr  (lane[AW-1:0]),
    .wr_data  (pd_wd),
    .init_val ('0),
    .rd_data  (pd_rd)
  );

  cfc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cells         = div_rsp.quot;
  assign credit_prod   = grains_in * cfg.grain;
  assign credit_sum    = {1'b0, tx_rd} + {9'd0, credit_prod};
  assign pend_sum      = {1'b0, pd_rd} + {8'd0, cells};
  assign pend_ge_grain = pend >= {16'd0, cfg.grain};
  assign pend_ge_max   = pend >= {8'd0, cfg.grain_max};

  // Divider requests and write-back of the modified counters
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {7'd0, {1'b0, pkt_bytes} + {1'b0, cfg.cell_bytes} - 17'd1};
    div_req.den   = {cfg.cell_bytes, 16'd0};
    div_req.steps = CELL_STEPS;
    tx_we = 1'b0;
    tx_wd = tx_rd;
    pd_we = 1'b0;
    pd_wd = pend;
    unique case (state)
      S_READ: begin
        if (cmd == CMD_CREDIT) begin
          // Saturate the returned credit at the counter range
          tx_we = 1'b1;
          tx_wd = credit_sum[CNT_W] ? CNT_MAX : credit_sum[CNT_W-1:0];
        end else if ((cmd == CMD_TX && !is_control) || cmd == CMD_RELEASE) begin
          div_req.start = 1'b1;
        end
      end
      S_CELLS: begin
        if (div_rsp.done && cmd == CMD_TX && tx_rd >= {7'd0, cells}) begin
          tx_we = 1'b1;
          tx_wd = tx_rd - {7'd0, cells};
        end
      end
      S_PCHK: begin
        priority if (!pend_ge_grain) begin
          pd_we = 1'b1;
        end else if (pend_ge_max) begin
          // Whole grains clip at 255; the rest stays pending
          pd_we = 1'b1;
          pd_wd = pend - {8'd0, cfg.grain_max};
        end else begin
          // Fewer than 255 grains: quotient fits in eight bits
          div_req.start = 1'b1;
          div_req.num   = pend;
          div_req.den   = {17'd0, cfg.grain, 7'd0};
          div_req.steps = GRAIN_STEPS;
        end
      end
      S_GRAIN: begin
        if (div_rsp.done) begin
          pd_we = 1'b1;
          pd_wd = div_rsp.rem;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // Drop the taken response unless the next one is loaded this cycle
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cmd         <= req.cmd;
            lane        <= req.lane;
            pkt_bytes   <= req.pkt_bytes;
            is_control  <= req.is_control;
            grains_in   <= req.grains_in;
            res_granted <= 1'b0;
            res_cvalid  <= 1'b0;
            res_lane    <= '0;
            res_grains  <= '0;
            // Drop out-of-range lanes and the unused command straight to a zero result
            if (lane_ok && (req.cmd == CMD_TX || req.cmd == CMD_CREDIT ||
                            req.cmd == CMD_RELEASE)) begin
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          if (cmd == CMD_TX && is_control) begin
            res_granted <= 1'b1;
            state       <= S_DONE;
          end else if (cmd == CMD_CREDIT) begin
            state <= S_DONE;
          end else begin
            state <= S_CELLS;
          end
        end
        S_CELLS: begin
          if (div_rsp.done) begin
            if (cmd == CMD_TX) begin
              res_granted <= tx_rd >= {7'd0, cells};
              state       <= S_DONE;
            end else begin
              pend  <= pend_sum[CNT_W] ? CNT_MAX : pend_sum[CNT_W-1:0];
              state <= S_PCHK;
            end
          end
        end
        S_PCHK: begin
          priority if (!pend_ge_grain) begin
            state <= S_DONE;
          end else if (pend_ge_max) begin
            res_cvalid <= 1'b1;
            res_lane   <= lane;
            res_grains <= GRAIN_SAT;
            state      <= S_DONE;
          end else begin
            res_cvalid <= 1'b1;
            res_lane   <= lane;
            state      <= S_GRAIN;
          end
        end
        S_GRAIN: begin
          if (div_rsp.done) begin
            res_grains <= div_rsp.quot[7:0];
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.tx_granted    <= res_granted;
            rsp.credit_valid  <= res_cvalid;
            rsp.credit_lane   <= res_lane;
            rsp.credit_grains <= res_grains;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst) acc |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> (!tx_we && !pd_we))
    else $error("counter written outside a request");
  a_grains_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.credit_valid) |-> (rsp.credit_grains != 8'd0 && !rsp.tx_granted))
    else $error("credit return without grains or with a grant");
  a_one_write: assert property (@(posedge clk) disable iff (rst) !(tx_we && pd_we))
    else $error("both counters written in one cycle");

endmodule

// ===== design/cfc_div.sv =====
// ----------------------------------------------------------------------------
// cfc_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module cfc_div (
  input  logic              clk,
  input  logic              rst,
  input  cfc_pkg::div_req_t req,
  output cfc_pkg::div_rsp_t rsp
);
  import cfc_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [QUOT_W-1:0] quot;
  logic              ge;

  assign ge = {{(DEN_W-CNT_W){1'b0}}, rem} >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= req.num;
        den  <= req.den;
        quot <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - den[CNT_W-1:0];
        end
        quot <= {quot[QUOT_W-2:0], ge};
        den  <= den >> 1;
        cnt  <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == 5'd1 && !req.start) |=> (done && !busy))
    else $error("divider did not finish after last step");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

// ===== design/cfc_lane_mem.sv =====
// ----------------------------------------------------------------------------
// cfc_lane_mem
// Per-lane counter memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module cfc_lane_mem #(
  parameter int NUM_LANES = 16,
  parameter int AW        = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cfc_pkg::CNT_W-1:0] wr_data,
  input  logic [cfc_pkg::CNT_W-1:0] init_val,
  output logic [cfc_pkg::CNT_W-1:0] rd_data
);
  import cfc_pkg::*;

  logic [CNT_W-1:0]     mem [NUM_LANES];
  logic [NUM_LANES-1:0] vld;
  logic [CNT_W-1:0]     rd_q;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  // An entry never written since reset or clear reads as the initial value
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : init_val;

endmodule

// ===== design/cfc_cfg.sv =====
// ----------------------------------------------------------------------------
// cfc_cfg
// APB configuration registers and derived divisor constants.
// ----------------------------------------------------------------------------
module cfc_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output cfc_pkg::cfg_t cfg
);
  import cfc_pkg::*;

  logic [7:0]       flit_bytes;
  logic [7:0]       flits_per_cell;
  logic [7:0]       return_grain;
  logic [CNT_W-1:0] initial_credit;
  logic [15:0]      cell_bytes;
  logic [15:0]      grain_max;
  logic [7:0]       f_eff;
  logic [7:0]       n_eff;
  logic [7:0]       g_eff;
  logic             wr;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      flit_bytes     <= RST_FLIT_BYTES;
      flits_per_cell <= RST_FLITS_CELL;
      return_grain   <= RST_RET_GRAIN;
      initial_credit <= RST_INIT_CREDIT;
    end else if (wr) begin
      unique case (idx)
        REG_FLIT_BYTES:  flit_bytes     <= pwdata[7:0];
        REG_FLITS_CELL:  flits_per_cell <= pwdata[7:0];
        REG_RET_GRAIN:   return_grain   <= pwdata[7:0];
        REG_INIT_CREDIT: initial_credit <= pwdata[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FLIT_BYTES:  prdata = {24'd0, flit_bytes};
      REG_FLITS_CELL:  prdata = {24'd0, flits_per_cell};
      REG_RET_GRAIN:   prdata = {24'd0, return_grain};
      REG_INIT_CREDIT: prdata = {8'd0, initial_credit};
    endcase
  end

  // Treat a zero setting as one
  assign f_eff = (flit_bytes == 8'd0) ? 8'd1 : flit_bytes;
  assign n_eff = (flits_per_cell == 8'd0) ? 8'd1 : flits_per_cell;
  assign g_eff = (return_grain == 8'd0) ? 8'd1 : return_grain;

  always_ff @(posedge clk) begin
    cell_bytes <= f_eff * n_eff;
    grain_max  <= GRAIN_SAT * g_eff;
  end

  assign cfg.grain       = g_eff;
  assign cfg.cell_bytes  = cell_bytes;
  assign cfg.grain_max   = grain_max;
  assign cfg.init_credit = initial_credit;
  assign cfg.credit_load = wr && (idx == REG_INIT_CREDIT);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-lane credit flow control block. A short
// directed pass and several register settings of random traffic run against
// an in-bench model of the lane counters; every response is compared field
// by field, in order, and the registers are read back after each new setting.
// ----------------------------------------------------------------------------
module tb_top;
  import cfc_pkg::*;

  localparam int NUM_LANES      = 16;
  localparam int NUM_PHASES     = 8;
  localparam int GENERAL_ITEMS  = 125;
  localparam int FLOOD_ITEMS    = 300;
  localparam int HOLD_OFF       = 40;    // release path latency plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam logic [3:0] FLOOD_LANE = 4'd7;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  lane;
    logic [15:0] nbytes;
    logic        ctrl;
    logic [7:0]  grains;
  } lane_req_t;

  typedef struct packed {
    logic       granted;
    logic       cvalid;
    logic [3:0] clane;
    logic [7:0] cgrains;
  } lane_rsp_t;

  typedef struct packed {
    lane_req_t req;
    logic      typed;  // response written out below rather than predicted
    lane_rsp_t want;
  } directed_row_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SEVEN, RDY_SPARSE} stall_mode_t;
  typedef enum logic {MIX_GENERAL, MIX_FLOOD} mix_t;

  localparam lane_rsp_t RSP_NONE  = '0;
  localparam lane_rsp_t RSP_GRANT = '{1'b1, 1'b0, 4'd0, 8'd0};

  // Reset settings: 64 bytes per cell, grain of one cell, 256 cells per lane.
  localparam directed_row_t DIRECTED_ROWS [23] = '{
    // cells for zero bytes are zero, so the request always passes
    '{'{CMD_TX,      4'd0,  16'd0,     1'b0, 8'd0},   1'b1, RSP_GRANT},
    // largest packet needs 1024 cells, more than the lane holds
    '{'{CMD_TX,      4'd15, 16'd65535, 1'b0, 8'd0},   1'b1, RSP_NONE},
    // exactly the whole lane credit, then nothing left for one byte
    '{'{CMD_TX,      4'd1,  16'd16384, 1'b0, 8'd0},   1'b1, RSP_GRANT},
    '{'{CMD_TX,      4'd1,  16'd1,     1'b0, 8'd0},   1'b1, RSP_NONE},
    // control packet bypasses the empty lane
    '{'{CMD_TX,      4'd1,  16'd65535, 1'b1, 8'd0},   1'b1, RSP_GRANT},
    // partner returns: largest and zero grains
    '{'{CMD_CREDIT,  4'd1,  16'd0,     1'b0, 8'd255}, 1'b1, RSP_NONE},
    '{'{CMD_CREDIT,  4'd1,  16'd0,     1'b0, 8'd0},   1'b1, RSP_NONE},
    '{'{CMD_TX,      4'd1,  16'd16320, 1'b0, 8'd0},   1'b1, RSP_GRANT},
    // releases: one cell, then nothing owed
    '{'{CMD_RELEASE, 4'd2,  16'd64,    1'b0, 8'd0},   1'b1, '{1'b0, 1'b1, 4'd2, 8'd1}},
    '{'{CMD_RELEASE, 4'd2,  16'd0,     1'b0, 8'd0},   1'b1, RSP_NONE},
    // 1024 cells owed: clamp at 255 grains and drain the rest in steps
    '{'{CMD_RELEASE, 4'd3,  16'd65535, 1'b0, 8'd0},   1'b1, '{1'b0, 1'b1, 4'd3, 8'd255}},
    '{'{CMD_RELEASE, 4'd3,  16'd0,     1'b0, 8'd0},   1'b1, '{1'b0, 1'b1, 4'd3, 8'd255}},
    '{'{CMD_RELEASE, 4'd3,  16'd0,     1'b0, 8'd0},   1'b1, '{1'b0, 1'b1, 4'd3, 8'd255}},
    '{'{CMD_RELEASE, 4'd3,  16'd0,     1'b0, 8'd0},   1'b1, '{1'b0, 1'b1, 4'd3, 8'd255}},
    '{'{CMD_RELEASE, 4'd3,  16'd0,     1'b0, 8'd0},   1'b1, '{1'b0, 1'b1, 4'd3, 8'd4}},
    // unused command with every field set: no effect
    '{'{CMD_UNUSED,  4'd5,  16'd100,   1'b1, 8'd200}, 1'b1, RSP_NONE},
    // fields that do not belong to the command are ignored
    '{'{CMD_CREDIT,  4'd14, 16'd65535, 1'b1, 8'd255}, 1'b1, RSP_NONE},
    '{'{CMD_RELEASE, 4'd4,  16'd65,    1'b1, 8'd255}, 1'b1, '{1'b0, 1'b1, 4'd4, 8'd2}},
    '{'{CMD_TX,      4'd14, 16'd65535, 1'b0, 8'd0},   1'b1, RSP_NONE},
    // leave these to the model
    '{'{CMD_TX,      4'd15, 16'd1,     1'b0, 8'd255}, 1'b0, RSP_NONE},
    '{'{CMD_TX,      4'd15, 16'd100,   1'b0, 8'd0},   1'b0, RSP_NONE},
    '{'{CMD_RELEASE, 4'd15, 16'd12345, 1'b0, 8'd7},   1'b0, RSP_NONE},
    '{'{CMD_CREDIT,  4'd15, 16'd0,     1'b0, 8'd128}, 1'b0, RSP_NONE}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cfc_req_if req_if();
  cfc_rsp_if rsp_if();

  credit_flow_control_per_lane #(
    .NUM_LANES (NUM_LANES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Lane model: register copies and per-lane counters
  logic [7:0]       cfg_flit;
  logic [7:0]       cfg_fpc;
  logic [7:0]       cfg_grain;
  logic [CNT_W-1:0] cfg_init;
  logic [CNT_W-1:0] tx_free [NUM_LANES];
  logic [CNT_W-1:0] owed_cells [NUM_LANES];

  lane_rsp_t   outcome_q [$];   // responses still owed by the block, oldest first
  int          fail_count;
  int          cmd_seen [4];
  int          grant_count;
  int          credit_count;
  int          setting_count;
  int          burst_left;
  bit          no_gaps;
  stall_mode_t stall_mode;
  logic [7:0]  stall_tick;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model of the block
  // ---------------------------------------------------------------------------

  // Bytes to cells, rounded up; a zero register counts as one.
  function automatic int unsigned cells_for(logic [15:0] nbytes);
    int unsigned per_flit, per_cell, span;
    per_flit = (cfg_flit == 8'd0) ? 1 : cfg_flit;
    per_cell = (cfg_fpc == 8'd0) ? 1 : cfg_fpc;
    span     = per_flit * per_cell;
    return (nbytes + span - 1) / span;
  endfunction

  // Add and clamp at the counter ceiling.
  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] base, int unsigned add);
    longint unsigned total;
    total = longint'(base) + longint'(add);
    return (total > CNT_MAX) ? CNT_MAX : total[CNT_W-1:0];
  endfunction

  // Advance the lane counters by one request and return the response it owes.
  function automatic lane_rsp_t credit_outcome(lane_req_t r);
    lane_rsp_t        res;
    int unsigned      need, grain, whole;
    logic [CNT_W-1:0] owed;
    res   = RSP_NONE;
    grain = (cfg_grain == 8'd0) ? 1 : cfg_grain;
    if (r.lane < NUM_LANES) begin
      case (r.cmd)
        CMD_TX: begin
          if (r.ctrl) begin
            res.granted = 1'b1;
          end else begin
            need = cells_for(r.nbytes);
            if (tx_free[r.lane] >= need) begin
              tx_free[r.lane] = tx_free[r.lane] - CNT_W'(need);
              res.granted     = 1'b1;
            end
          end
        end
        CMD_CREDIT: begin
          tx_free[r.lane] = sat_sum(tx_free[r.lane], r.grains * grain);
        end
        CMD_RELEASE: begin
          owed = sat_sum(owed_cells[r.lane], cells_for(r.nbytes));
          if (owed >= grain) begin
            whole = owed / grain;
            if (whole > GRAIN_SAT) whole = GRAIN_SAT;
            owed        = owed - CNT_W'(whole * grain);
            res.cvalid  = 1'b1;
            res.clane   = r.lane;
            res.cgrains = whole[7:0];
          end
          owed_cells[r.lane] = owed;
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_FLIT_BYTES: cfg_flit  = val[7:0];
      REG_FLITS_CELL: cfg_fpc   = val[7:0];
      REG_RET_GRAIN:  cfg_grain = val[7:0];
      default: begin
        // writing the initial credit also refills every lane
        cfg_init = val[CNT_W-1:0];
        for (int i = 0; i < NUM_LANES; i++) tx_free[i] = cfg_init;
      end
    endcase
  endfunction

  function automatic logic [31:0] register_value(logic [1:0] idx);
    case (idx)
      REG_FLIT_BYTES: return {24'd0, cfg_flit};
      REG_FLITS_CELL: return {24'd0, cfg_fpc};
      REG_RET_GRAIN:  return {24'd0, cfg_grain};
      default:        return {8'd0, cfg_init};
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Setup cycle, then access cycle; the write lands at the edge with pready.
  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read back and compare the bits the register actually holds.
  task automatic read_register(logic [1:0] idx);
    logic [31:0] mask;
    mask = (idx == REG_INIT_CREDIT) ? 32'h00FF_FFFF : 32'h0000_00FF;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != register_value(idx)) begin
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, register_value(idx), prdata & mask);
      fail_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one request, holding it until taken. Bursts of random length are
  // separated by random gaps unless this setting runs back to back.
  task automatic send_request(lane_req_t r, logic typed, lane_rsp_t want);
    int gap;
    lane_rsp_t model_rsp;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        @(negedge clk);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    req_if.valid      = 1'b1;
    req_if.cmd        = r.cmd;
    req_if.lane       = r.lane;
    req_if.pkt_bytes  = r.nbytes;
    req_if.is_control = r.ctrl;
    req_if.grains_in  = r.grains;
    do @(posedge clk); while (!req_if.ready);
    // taken at this edge: advance the model even when the row types its answer
    model_rsp = credit_outcome(r);
    outcome_q.push_back(typed ? want : model_rsp);
    cmd_seen[r.cmd]++;
  endtask

  // Drop the request line, drain every owed response, then hold off a little
  // so no release is still in the divider when the registers change.
  task automatic settle_block();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  function automatic lane_req_t random_request(mix_t mix);
    lane_req_t r;
    int        pick, size_kind;
    pick      = $urandom_range(0, 99);
    size_kind = $urandom_range(0, 9);
    r.lane    = 4'($urandom_range(0, 15));
    r.ctrl    = ($urandom_range(0, 6) == 0);
    r.grains  = 8'($urandom_range(0, 255));
    case (size_kind)
      0:       r.nbytes = 16'd0;
      1:       r.nbytes = 16'hFFFF;
      2, 3, 4, 5, 6: r.nbytes = 16'($urandom_range(0, 1023));
      default: r.nbytes = 16'($urandom_range(0, 65535));
    endcase
    if (pick < 45)      r.cmd = CMD_TX;
    else if (pick < 65) r.cmd = CMD_CREDIT;
    else if (pick < 95) r.cmd = CMD_RELEASE;
    else                r.cmd = CMD_UNUSED;
    // flood one lane with full-size releases until its owed count saturates
    if (mix == MIX_FLOOD && pick < 95) begin
      r.cmd    = CMD_RELEASE;
      r.lane   = FLOOD_LANE;
      r.nbytes = 16'hFFFF;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: stall on a pattern redrawn whenever the 8-bit tick wraps; the tick counts clock cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RDY_ALWAYS: rsp_if.ready <= 1'b1;
      RDY_COIN:   rsp_if.ready <= ($urandom_range(0, 1) == 0);
      RDY_SEVEN:  rsp_if.ready <= ((stall_tick % 7) < 4);
      default:    rsp_if.ready <= (stall_tick[2:0] == 3'd0);
    endcase
  end

  // Compare each response taken with the oldest one owed.
  always @(posedge clk) begin : check_rsp
    lane_rsp_t got, want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.tx_granted, rsp_if.credit_valid, rsp_if.credit_lane,
              rsp_if.credit_grains};
      if (outcome_q.size() == 0) begin
        $display("%0t: response with nothing outstanding, expected none, actual %h",
                 $time, got);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("tx_granted", want.granted, got.granted);
        check_field("credit_valid", want.cvalid, got.cvalid);
        check_field("credit_lane", want.clane, got.clane);
        check_field("credit_grains", want.cgrains, got.cgrains);
        grant_count  += got.granted;
        credit_count += got.cvalid;
      end
    end
  end

  // Abort when neither channel nor the register port moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles, %0d responses outstanding",
             $time, WATCHDOG_LIMIT, outcome_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]       fb, fpc, rg;
    logic [CNT_W-1:0] ic;
    int               items;
    mix_t             mix;

    // known values on every input from time zero
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_TX;
    req_if.lane       = '0;
    req_if.pkt_bytes  = '0;
    req_if.is_control = 1'b0;
    req_if.grains_in  = '0;
    rsp_if.ready      = 1'b0;
    stall_tick        = 8'd1;
    stall_mode        = RDY_ALWAYS;
    fail_count        = 0;
    grant_count       = 0;
    credit_count      = 0;
    setting_count     = 1;
    burst_left        = 0;
    no_gaps           = 1'b0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;

    // model reset state mirrors the block's
    cfg_flit  = RST_FLIT_BYTES;
    cfg_fpc   = RST_FLITS_CELL;
    cfg_grain = RST_RET_GRAIN;
    cfg_init  = RST_INIT_CREDIT;
    for (int i = 0; i < NUM_LANES; i++) begin
      tx_free[i]    = RST_INIT_CREDIT;
      owed_cells[i] = '0;
    end

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // confirm reset values before any write
    for (int i = 0; i < 4; i++) read_register(i[1:0]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      mix   = MIX_GENERAL;
      items = GENERAL_ITEMS;
      if (p == 0) begin
        // walk the directed rows under reset settings
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
          send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end else begin
        case (p)
          1: begin
            // zero registers count as one; lanes start empty
            fb = 8'd0; fpc = 8'd0; rg = 8'd0; ic = '0;
          end
          2: begin
            fb = 8'd255; fpc = 8'd255; rg = 8'd255; ic = CNT_MAX;
          end
          3: begin
            // one byte per cell so a single lane's owed count hits the ceiling
            fb = 8'd1; fpc = 8'd1; rg = 8'd1; ic = CNT_MAX;
            mix   = MIX_FLOOD;
            items = FLOOD_ITEMS;
          end
          default: begin
            fb  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(1, 32));
            fpc = 8'($urandom_range(1, 8));
            rg  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(1, 16));
            ic  = CNT_W'($urandom_range(0, 2048));
          end
        endcase
        settle_block();
        write_register(REG_FLIT_BYTES, {24'd0, fb});
        write_register(REG_FLITS_CELL, {24'd0, fpc});
        write_register(REG_RET_GRAIN, {24'd0, rg});
        write_register(REG_INIT_CREDIT, {8'd0, ic});
        for (int i = 0; i < 4; i++) read_register(i[1:0]);
        setting_count++;
      end

      // some settings run back to back, the rest in bursts
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      repeat (items) send_request(random_request(mix), 1'b0, RSP_NONE);
    end

    settle_block();

    $display("Ran %0d transmit, %0d partner credit, %0d release and %0d unused requests",
             cmd_seen[CMD_TX], cmd_seen[CMD_CREDIT], cmd_seen[CMD_RELEASE],
             cmd_seen[CMD_UNUSED]);
    $display("under %0d register settings; saw %0d grants, %0d credit returns, %0d errors",
             setting_count, grant_count, credit_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
